// File: rtl/oct_kclock_linear_resampler_core_assert.svh
// ----------------------------------------------------------------------------
// oct_kclock_linear_resampler_core_assert - assertion macros
// Shorthand for clocked concurrent assertions with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef OCT_KCLOCK_LINEAR_RESAMPLER_CORE_ASSERT_SVH
`define OCT_KCLOCK_LINEAR_RESAMPLER_CORE_ASSERT_SVH

// consequent checked in the cycle after the antecedent
`define OKL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

// consequent checked in the same cycle
`define OKL_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/okl_pkg.sv
// ----------------------------------------------------------------------------
// okl_pkg - shared types and constants of the k-clock resampler
// Item codes, coefficient reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package okl_pkg;

	typedef enum logic [1:0] {
		ACT_REF     = 2'd0,
		ACT_SAMPLE  = 2'd1,
		ACT_REQUEST = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		COEF_C0 = 2'd0,
		COEF_C1 = 2'd1,
		COEF_C2 = 2'd2,
		COEF_C3 = 2'd3
	} coef_idx_t;

	typedef enum logic [2:0] {
		MS_CHUNK0,
		MS_CHUNK1,
		MS_CHUNK2,
		MS_FHI,
		MS_FLO
	} mul_sel_t;

	typedef enum logic [1:0] {
		BASE_ZERO,
		BASE_COEF,
		BASE_SUM
	} base_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_24,
		SH_32,
		SH_64
	} shift_t;

	localparam logic signed [63:0] COEF_C0_RST = 64'sd3199244585293316;
	localparam logic signed [63:0] COEF_C1_RST = 64'sd241528048015880;
	localparam logic signed [63:0] COEF_C2_RST = 64'sd70357485179;
	localparam logic signed [63:0] COEF_C3_RST = -64'sd31319721;

	typedef struct packed {
		logic      ref_wr;
		logic      sample_rd;
		logic      line_wr;
		logic      poly_init;
		logic      mul_en;
		mul_sel_t  mul_sel;
		logic      sum_en;
		base_t     sum_base;
		shift_t    sum_shift;
		logic      acc_load;
		coef_idx_t coef_sel;
		logic      decode;
		logic      rd_a;
		logic      rd_b;
		logic      diff;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic hit;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/okl_datapath.sv
// ----------------------------------------------------------------------------
// okl_datapath - stores, coefficient registers and shared multiplier
// Horner evaluation of the grid position, line lookup and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module okl_datapath #(
	parameter int LINE_LENGTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [63:0]           cfg_wdata,
	input  logic [9:0]            position,
	input  logic [15:0]           raw_sample,
	input  logic [23:0]           reference_word,
	input  okl_pkg::dp_cmd_t      cmd,
	output okl_pkg::dp_sts_t      sts,
	output logic signed [24:0]    resampled_value,
	output logic                  out_of_range
);
	import okl_pkg::*;

	localparam int AW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
	localparam logic [AW-1:0] LastIdx = AW'(LINE_LENGTH - 1);
	localparam logic [47:0] LenIp = 48'(LINE_LENGTH);

	logic [23:0]        ref_mem  [LINE_LENGTH];
	logic signed [24:0] line_mem [LINE_LENGTH];

	logic signed [63:0] c0_q, c1_q, c2_q, c3_q;
	logic signed [95:0] acc_q, sum_q;
	logic [10:0]        t_q;
	logic signed [57:0] prod_s1;
	logic signed [25:0] d_q;
	logic signed [24:0] a_q, line_rd_q;
	logic [23:0]        ref_rd_q;
	logic [15:0]        raw_q;
	logic [AW-1:0]      ld_addr_q, ia_q, ib_q;
	logic               ld_ok_q, hit_q;
	logic signed [24:0] val_q;
	logic               oor_q;

	logic [AW-1:0]      addr;
	logic               pos_ok;
	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [57:0] prod_d;
	logic signed [95:0] prod_ext, shifted, base, sum_d;
	logic signed [63:0] coef;
	logic [47:0]        ip;
	logic               neg, mid, endp, hit;
	logic [AW-1:0]      ia_d, ib_d;
	logic signed [24:0] interp;

	assign addr   = AW'(position);
	assign pos_ok = 32'(position) < 32'(LINE_LENGTH);

	always_comb begin
		unique case (cmd.coef_sel)
			COEF_C0: coef = c0_q;
			COEF_C1: coef = c1_q;
			COEF_C2: coef = c2_q;
			COEF_C3: coef = c3_q;
		endcase
	end

	always_comb begin
		case (cmd.mul_sel)
			MS_CHUNK0: begin
				mul_a = {1'b0, acc_q[31:0]};
				mul_b = {14'd0, t_q};
			end
			MS_CHUNK1: begin
				mul_a = {1'b0, acc_q[63:32]};
				mul_b = {14'd0, t_q};
			end
			MS_CHUNK2: begin
				mul_a = {1'b0, acc_q[95:64]};
				mul_b = {14'd0, t_q};
			end
			MS_FHI: begin
				mul_a = {{7{d_q[25]}}, d_q};
				mul_b = {1'b0, acc_q[47:24]};
			end
			default: begin
				mul_a = {{7{d_q[25]}}, d_q};
				mul_b = {1'b0, acc_q[23:0]};
			end
		endcase
	end

	assign prod_d   = mul_a * mul_b;
	assign prod_ext = {{38{prod_s1[57]}}, prod_s1};

	always_comb begin
		case (cmd.sum_shift)
			SH_0:    shifted = prod_ext;
			SH_24:   shifted = prod_ext << 24;
			SH_32:   shifted = prod_ext << 32;
			default: shifted = prod_ext << 64;
		endcase
		case (cmd.sum_base)
			BASE_COEF: base = {{32{coef[63]}}, coef};
			BASE_SUM:  base = sum_q;
			default:   base = '0;
		endcase
	end

	assign sum_d = base + shifted;

	// grid position decode: integer part ip, 48 fraction bits
	assign ip   = acc_q[95:48];
	assign neg  = acc_q[95];
	assign mid  = !neg && (ip != 48'd0) && (ip < LenIp);
	assign endp = !neg && (ip == LenIp) && (acc_q[47:0] == 48'd0);
	assign hit  = mid || endp;
	assign ia_d = endp ? LastIdx : ip[AW-1:0] - AW'(1);
	assign ib_d = endp ? LastIdx : ip[AW-1:0];

	assign sts.hit = hit;

	assign interp = a_q + sum_q[72:48];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q <= COEF_C0_RST;
			c1_q <= COEF_C1_RST;
			c2_q <= COEF_C2_RST;
			c3_q <= COEF_C3_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				COEF_C0: c0_q <= cfg_wdata;
				COEF_C1: c1_q <= cfg_wdata;
				COEF_C2: c2_q <= cfg_wdata;
				COEF_C3: c3_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sample_rd) begin
			raw_q     <= raw_sample;
			ld_addr_q <= addr;
			ld_ok_q   <= pos_ok;
		end
		if (cmd.poly_init) begin
			acc_q <= {{32{c3_q[63]}}, c3_q};
			t_q   <= {1'b0, position} + 11'd1;
		end else if (cmd.acc_load) begin
			acc_q <= sum_d;
		end
		if (cmd.mul_en) begin
			prod_s1 <= prod_d;
		end
		if (cmd.sum_en) begin
			sum_q <= sum_d;
		end
		if (cmd.decode) begin
			hit_q <= hit;
			ia_q  <= ia_d;
			ib_q  <= ib_d;
		end
		if (cmd.rd_b) begin
			a_q <= line_rd_q;
		end
		if (cmd.diff) begin
			d_q <= {line_rd_q[24], line_rd_q} - {a_q[24], a_q};
		end
		if (cmd.out_load) begin
			val_q <= hit_q ? interp : 25'sd0;
			oor_q <= !hit_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ref_wr && pos_ok) begin
			ref_mem[addr] <= reference_word;
		end
		if (cmd.sample_rd) begin
			ref_rd_q <= ref_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.line_wr && ld_ok_q) begin
			line_mem[ld_addr_q] <= {1'b0, raw_q, 8'h00} - {1'b0, ref_rd_q};
		end
		if (cmd.rd_a) begin
			line_rd_q <= line_mem[ia_q];
		end else if (cmd.rd_b) begin
			line_rd_q <= line_mem[ib_q];
		end
	end

	assign resampled_value = val_q;
	assign out_of_range    = oor_q;

endmodule

`default_nettype wire

// File: rtl/okl_ctrl.sv
// ----------------------------------------------------------------------------
// okl_ctrl - sequencer of the k-clock resampler
// Steps loads, the Horner loop and the interpolation through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module okl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        action,
	input  logic              out_ready,
	input  okl_pkg::dp_sts_t  sts,
	output logic              in_ready,
	output logic              out_valid,
	output okl_pkg::dp_cmd_t  cmd
);
	import okl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_WR,
		S_POLY,
		S_DECODE,
		S_RD_A,
		S_RD_B,
		S_DIFF,
		S_IMUL,
		S_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] k_q;
	logic [1:0] step_q;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_REF:     cmd.ref_wr    = 1'b1;
						ACT_SAMPLE:  cmd.sample_rd = 1'b1;
						ACT_REQUEST: cmd.poly_init = 1'b1;
						default:     ;
					endcase
				end
			end
			S_LD_WR: cmd.line_wr = 1'b1;
			S_POLY: begin
				if (step_q == 2'd0) begin
					cmd.coef_sel = COEF_C2;
				end else if (step_q == 2'd1) begin
					cmd.coef_sel = COEF_C1;
				end else begin
					cmd.coef_sel = COEF_C0;
				end
				case (k_q)
					2'd0: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MS_CHUNK0;
					end
					2'd1: begin
						cmd.mul_en    = 1'b1;
						cmd.mul_sel   = MS_CHUNK1;
						cmd.sum_en    = 1'b1;
						cmd.sum_base  = BASE_COEF;
						cmd.sum_shift = SH_0;
					end
					2'd2: begin
						cmd.mul_en    = 1'b1;
						cmd.mul_sel   = MS_CHUNK2;
						cmd.sum_en    = 1'b1;
						cmd.sum_base  = BASE_SUM;
						cmd.sum_shift = SH_32;
					end
					default: begin
						cmd.sum_en    = 1'b1;
						cmd.sum_base  = BASE_SUM;
						cmd.sum_shift = SH_64;
						cmd.acc_load  = 1'b1;
					end
				endcase
			end
			S_DECODE: cmd.decode = 1'b1;
			S_RD_A:   cmd.rd_a   = 1'b1;
			S_RD_B:   cmd.rd_b   = 1'b1;
			S_DIFF:   cmd.diff   = 1'b1;
			S_IMUL: begin
				case (k_q)
					2'd0: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MS_FHI;
					end
					2'd1: begin
						cmd.mul_en    = 1'b1;
						cmd.mul_sel   = MS_FLO;
						cmd.sum_en    = 1'b1;
						cmd.sum_base  = BASE_ZERO;
						cmd.sum_shift = SH_24;
					end
					default: begin
						cmd.sum_en    = 1'b1;
						cmd.sum_base  = BASE_SUM;
						cmd.sum_shift = SH_0;
					end
				endcase
			end
			S_FIN: cmd.out_load = !out_valid_q || out_ready;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= 2'd0;
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (action)
							ACT_SAMPLE: state_q <= S_LD_WR;
							ACT_REQUEST: begin
								state_q <= S_POLY;
								k_q     <= 2'd0;
								step_q  <= 2'd0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LD_WR: state_q <= S_IDLE;
				S_POLY: begin
					if (k_q == 2'd3) begin
						k_q <= 2'd0;
						if (step_q == 2'd2) begin
							state_q <= S_DECODE;
						end else begin
							step_q <= step_q + 2'd1;
						end
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_DECODE: state_q <= sts.hit ? S_RD_A : S_FIN;
				S_RD_A:   state_q <= S_RD_B;
				S_RD_B:   state_q <= S_DIFF;
				S_DIFF: begin
					state_q <= S_IMUL;
					k_q     <= 2'd0;
				end
				S_IMUL: begin
					if (k_q == 2'd2) begin
						k_q     <= 2'd0;
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_FIN: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/oct_kclock_linear_resampler_core.sv
// ----------------------------------------------------------------------------
// oct_kclock_linear_resampler_core - k-clock linear resampler, top level
// Loads: a reference is written on acceptance; a sample reads the reference,
// then writes the line. A request admits no item until its result is loaded.
// Horner: 3 steps, one shared 33x25 multiplier; off-line skips interpolation.
// Reset (arst_n, async): coefficients to defaults, idle; stores undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module oct_kclock_linear_resampler_core #(
	parameter int LINE_LENGTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [9:0]         position,
	input  logic [15:0]        raw_sample,
	input  logic [23:0]        reference_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [24:0] resampled_value,
	output logic               out_of_range
);
	import okl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	okl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	okl_datapath #(
		.LINE_LENGTH (LINE_LENGTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.position        (position),
		.raw_sample      (raw_sample),
		.reference_word  (reference_word),
		.cmd             (cmd),
		.sts             (sts),
		.resampled_value (resampled_value),
		.out_of_range    (out_of_range)
	);

endmodule

`default_nettype wire

// File: rtl/okl_checker.sv
// ----------------------------------------------------------------------------
// okl_checker - port-level checks of the k-clock resampler
// Result channel handshake and item timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "oct_kclock_linear_resampler_core_assert.svh"

module okl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        action,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [24:0] resampled_value,
	input logic              out_of_range
);
	import okl_pkg::*;

	`OKL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result transaction dropped while stalled")

	`OKL_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(resampled_value) && $stable(out_of_range), "result payload changed while stalled")

	`OKL_ASSERT_SAME(a_oor_zero, clk, arst_n, out_valid && out_of_range, resampled_value == 25'sd0, "out-of-range result carries a value")

	`OKL_ASSERT_NEXT(a_req_busy, clk, arst_n, in_valid && in_ready && action == ACT_REQUEST, !in_ready, "request transaction did not occupy the block")

	`OKL_ASSERT_NEXT(a_ref_quick, clk, arst_n, in_valid && in_ready && action == ACT_REF, in_ready, "reference load held the block")

endmodule

bind oct_kclock_linear_resampler_core okl_checker u_okl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.action          (action),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.resampled_value (resampled_value),
	.out_of_range    (out_of_range)
);

`default_nettype wire
